// ===== sv/ilsu_pkg.sv =====
// ----------------------------------------------------------------------------
// ilsu_pkg
// Types and constants for the implicit Lorentz source update pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ilsu_pkg;

    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE         = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_MASS_RATIO = 8'd1;

    localparam logic [30:0]        STEP_SIZE_RST = 31'd0;
    localparam logic signed [31:0] CMR_RST       = 32'sd65536;   // 1.0

    localparam logic signed [63:0] W_MAX = 64'sd8388607;
    localparam logic signed [63:0] W_MIN = -64'sd8388608;

    typedef struct packed {
        logic signed [31:0] dens_in;
        logic signed [31:0] momx_in;
        logic signed [31:0] momy_in;
        logic signed [31:0] momz_in;
        logic signed [31:0] energy_in;
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
        logic               last_cell_in;
    } ilsu_in_t;

    typedef struct packed {
        logic signed [31:0] dens_out;
        logic signed [31:0] momx_out;
        logic signed [31:0] momy_out;
        logic signed [31:0] momz_out;
        logic signed [31:0] energy_out;
        logic               last_cell_out;
    } ilsu_out_t;

    // values that ride along untouched
    typedef struct packed {
        logic signed [31:0] dens;
        logic signed [31:0] energy;
        logic               last_cell;
    } ilsu_pass_t;

    // one momentum lane inside the restoring divider
    typedef struct packed {
        logic [32:0] rem;
        logic [32:0] quo;
        logic [32:0] low;
        logic        neg;
        logic        ovf;
    } ilsu_div_t;

endpackage

`default_nettype wire

// ===== sv/implicit_lorentz_source_update.sv =====
// ----------------------------------------------------------------------------
// implicit_lorentz_source_update
// Implicit-Euler Lorentz rotation of cell momentum, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one cell (conserved values, B field, flag).
//   m_valid/m_ready/m_data return density and energy unchanged, the rotated
//   and saturated momentum, and the last-cell flag.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write step_size (index 0) and
//   charge_mass_ratio (index 1); other indices are ignored. cfg_ready is
//   always high. Write only while the pipeline is empty.
// Pipeline: 19 register stages: nine front-end stages (input, spacer,
//   field scaling, field rounding, products, sums, dot weighting,
//   numerator, divider set-up), then a radix-2 restoring divider
//   resolving four quotient bits per stage (one in the last) over nine
//   stages, then the saturating output register.
// Throughput: one cell per cycle while m_ready does not stall the output.
// Stall: each stage holds while its successor is full and stalled; bubbles
//   still close up, so s_ready drops only when every stage is occupied and
//   m_ready is low.
// Reset: clears all valid bits and loads the register defaults
//   (step_size 0, charge_mass_ratio 1.0).
// ----------------------------------------------------------------------------
`default_nettype none

module implicit_lorentz_source_update (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire ilsu_pkg::ilsu_in_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output ilsu_pkg::ilsu_out_t                    m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ilsu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                       cfg_data
);
    import ilsu_pkg::*;

    localparam int DIV_BITS = 33;
    localparam int DIV_PER  = 4;
    localparam int NDIV     = (DIV_BITS + DIV_PER - 1) / DIV_PER;

    localparam int ST_IN   = 0;
    localparam int ST_DLY  = 1;
    localparam int ST_PROD = 2;
    localparam int ST_W    = 3;
    localparam int ST_MUL  = 4;
    localparam int ST_SUM  = 5;
    localparam int ST_DW   = 6;
    localparam int ST_N    = 7;
    localparam int ST_PREP = 8;
    localparam int ST_DIV0 = 9;
    localparam int ST_OUT  = ST_DIV0 + NDIV;
    localparam int NSTG    = ST_OUT + 1;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [30:0]        step_reg;
    logic signed [31:0] cmr_reg;
    logic signed [63:0] cprod_reg;
    logic signed [31:0] c_reg;
    logic signed [31:0] c_next;
    logic signed [63:0] c_rnd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_SIZE_RST;
            cmr_reg  <= CMR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_STEP_SIZE:         step_reg <= cfg_data[30:0];
                CFG_CHARGE_MASS_RATIO: cmr_reg  <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        c_rnd = (cprod_reg + 64'sd32768) >>> 16;
        if (c_rnd > 64'sd2147483647)
            c_next = 32'sh7FFFFFFF;
        else if (c_rnd < -64'sd2147483648)
            c_next = 32'sh80000000;
        else
            c_next = c_rnd[31:0];
    end

    always_ff @(posedge aclk) begin
        cprod_reg <= $signed({1'b0, step_reg}) * cmr_reg;
        c_reg     <= c_next;
    end

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   en;
    logic [NSTG-1:0] v_in;

    assign en[NSTG] = m_ready;
    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_en
            assign en[k] = !v_reg[k] || en[k+1];
        end
    endgenerate

    assign v_in    = {v_reg[NSTG-2:0], s_valid};
    assign s_ready = en[0];
    assign m_valid = v_reg[ST_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (en[i]) v_reg[i] <= v_in[i];
            end
        end
    end

    ilsu_pass_t pass_reg [ST_OUT];

    generate
        for (k = 0; k < ST_OUT; k++) begin : g_pass
            if (k == 0) begin : g_first
                always_ff @(posedge aclk) begin
                    if (en[k]) begin
                        pass_reg[k].dens      <= s_data.dens_in;
                        pass_reg[k].energy    <= s_data.energy_in;
                        pass_reg[k].last_cell <= s_data.last_cell_in;
                    end
                end
            end else begin : g_rest
                always_ff @(posedge aclk) begin
                    if (en[k]) pass_reg[k] <= pass_reg[k-1];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // arithmetic front end
    // ------------------------------------------------------------------
    logic signed [31:0] b0_reg [3];
    logic signed [31:0] f0_reg [3];
    logic signed [31:0] b1_reg [3];
    logic signed [31:0] f1_reg [3];
    logic signed [31:0] b2_reg [3];
    logic signed [63:0] p2_reg [3];
    logic signed [31:0] b3_reg [3];
    logic signed [23:0] w3_reg [3];
    logic signed [23:0] w3_next [3];
    logic signed [63:0] w_rnd [3];
    logic signed [31:0] b4_reg [3];
    logic signed [23:0] w4_reg [3];
    logic signed [55:0] wb4_reg [3];   // w_i * b_i
    logic signed [55:0] xa4_reg [3];   // first term of cross product
    logic signed [55:0] xb4_reg [3];   // second term
    logic signed [47:0] sq4_reg [3];
    logic signed [31:0] b5_reg [3];
    logic signed [23:0] w5_reg [3];
    logic signed [56:0] x5_reg [3];
    logic signed [41:0] dot5_reg;
    logic [31:0]        d5_reg;
    logic signed [57:0] dot_sum;
    logic signed [57:0] dot_rnd;
    logic [49:0]        mag2_sum;
    logic [49:0]        mag2_rnd;
    logic signed [63:0] dw6_reg [3];
    logic signed [65:0] dw_full [3];
    logic signed [63:0] bs6_reg [3];
    logic [31:0]        d6_reg;
    logic signed [63:0] n7_reg [3];
    logic [31:0]        d7_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_IN]) begin
            b0_reg[0] <= s_data.momx_in;
            b0_reg[1] <= s_data.momy_in;
            b0_reg[2] <= s_data.momz_in;
            f0_reg[0] <= s_data.field_x;
            f0_reg[1] <= s_data.field_y;
            f0_reg[2] <= s_data.field_z;
        end
        // spacer stage: keeps the registered scale factor ahead of the data
        if (en[ST_DLY]) begin
            b1_reg <= b0_reg;
            f1_reg <= f0_reg;
        end
        if (en[ST_PROD]) begin
            b2_reg <= b1_reg;
            for (int i = 0; i < 3; i++) p2_reg[i] <= c_reg * f1_reg[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rnd[i] = (p2_reg[i] + 64'sd32768) >>> 16;
            if (w_rnd[i] > W_MAX)
                w3_next[i] = W_MAX[23:0];
            else if (w_rnd[i] < W_MIN)
                w3_next[i] = W_MIN[23:0];
            else
                w3_next[i] = w_rnd[i][23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_W]) begin
            b3_reg <= b2_reg;
            w3_reg <= w3_next;
        end
        if (en[ST_MUL]) begin
            b4_reg <= b3_reg;
            w4_reg <= w3_reg;
            for (int i = 0; i < 3; i++) begin
                wb4_reg[i] <= w3_reg[i] * b3_reg[i];
                sq4_reg[i] <= w3_reg[i] * w3_reg[i];
            end
            xa4_reg[0] <= w3_reg[1] * b3_reg[2];
            xb4_reg[0] <= w3_reg[2] * b3_reg[1];
            xa4_reg[1] <= w3_reg[2] * b3_reg[0];
            xb4_reg[1] <= w3_reg[0] * b3_reg[2];
            xa4_reg[2] <= w3_reg[0] * b3_reg[1];
            xb4_reg[2] <= w3_reg[1] * b3_reg[0];
        end
    end

    always_comb begin
        dot_sum  = 58'(wb4_reg[0]) + 58'(wb4_reg[1]) + 58'(wb4_reg[2]);
        dot_rnd  = (dot_sum + 58'sd32768) >>> 16;
        mag2_sum = 50'($unsigned(sq4_reg[0])) + 50'($unsigned(sq4_reg[1]))
                 + 50'($unsigned(sq4_reg[2]));
        mag2_rnd = (mag2_sum + 50'd32768) >> 16;
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            b5_reg   <= b4_reg;
            w5_reg   <= w4_reg;
            dot5_reg <= dot_rnd[41:0];
            d5_reg   <= 32'd65536 + mag2_rnd[31:0];
            for (int i = 0; i < 3; i++)
                x5_reg[i] <= 57'(xa4_reg[i]) - 57'(xb4_reg[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) dw_full[i] = dot5_reg * w5_reg[i];
    end

    always_ff @(posedge aclk) begin
        if (en[ST_DW]) begin
            d6_reg <= d5_reg;
            for (int i = 0; i < 3; i++) begin
                dw6_reg[i] <= dw_full[i][63:0];
                bs6_reg[i] <= (64'(b5_reg[i]) <<< 16) - 64'(x5_reg[i]);
            end
        end
        if (en[ST_N]) begin
            d7_reg <= d6_reg;
            for (int i = 0; i < 3; i++) n7_reg[i] <= bs6_reg[i] + dw6_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // divider set-up: magnitude plus half divisor, overflow pre-check
    // ------------------------------------------------------------------
    ilsu_div_t   prep_reg [3];
    ilsu_div_t   prep_next [3];
    logic [31:0] d8_reg;
    logic [63:0] mag [3];
    logic [64:0] num [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = n7_reg[i][63] ? (64'd0 - $unsigned(n7_reg[i]))
                                   : $unsigned(n7_reg[i]);
            num[i] = {1'b0, mag[i]} + {34'd0, d7_reg[31:1]};
            prep_next[i].neg = n7_reg[i][63];
            prep_next[i].ovf = (num[i][64:33] >= d7_reg);
            prep_next[i].rem = {1'b0, num[i][64:33]};
            prep_next[i].low = num[i][32:0];
            prep_next[i].quo = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_PREP]) begin
            d8_reg   <= d7_reg;
            prep_reg <= prep_next;
        end
    end

    // ------------------------------------------------------------------
    // restoring divider, DIV_PER quotient bits per stage, fewer in the last
    // ------------------------------------------------------------------
    ilsu_div_t   div_reg [NDIV][3];
    logic [31:0] div_d_reg [NDIV];

    genvar s;
    generate
        for (s = 0; s < NDIV; s++) begin : g_div
            localparam int NSTEP = (DIV_BITS - s * DIV_PER < DIV_PER)
                                 ? (DIV_BITS - s * DIV_PER) : DIV_PER;
            ilsu_div_t   lane_in [3];
            ilsu_div_t   lane_nx [3];
            logic [31:0] d_in;

            if (s == 0) begin : g_src0
                assign lane_in = prep_reg;
                assign d_in    = d8_reg;
            end else begin : g_srcn
                assign lane_in = div_reg[s-1];
                assign d_in    = div_d_reg[s-1];
            end

            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    lane_nx[i] = lane_in[i];
                    for (int j = 0; j < NSTEP; j++) begin
                        lane_nx[i].rem = {lane_nx[i].rem[31:0], lane_nx[i].low[32]};
                        lane_nx[i].low = {lane_nx[i].low[31:0], 1'b0};
                        if (lane_nx[i].rem >= {1'b0, d_in}) begin
                            lane_nx[i].rem = lane_nx[i].rem - {1'b0, d_in};
                            lane_nx[i].quo = {lane_nx[i].quo[31:0], 1'b1};
                        end else begin
                            lane_nx[i].quo = {lane_nx[i].quo[31:0], 1'b0};
                        end
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (en[ST_DIV0+s]) begin
                    div_reg[s]   <= lane_nx;
                    div_d_reg[s] <= d_in;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // sign restore and saturation
    // ------------------------------------------------------------------
    logic signed [31:0] mom [3];
    ilsu_out_t          out_reg;
    ilsu_div_t          fin [3];

    assign fin = div_reg[NDIV-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!fin[i].neg) begin
                if (fin[i].ovf || fin[i].quo > 33'h07FFFFFFF)
                    mom[i] = 32'sh7FFFFFFF;
                else
                    mom[i] = $signed(fin[i].quo[31:0]);
            end else begin
                if (fin[i].ovf || fin[i].quo > 33'h080000000)
                    mom[i] = 32'sh80000000;
                else
                    mom[i] = $signed(32'd0 - fin[i].quo[31:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            out_reg.dens_out      <= pass_reg[ST_OUT-1].dens;
            out_reg.energy_out    <= pass_reg[ST_OUT-1].energy;
            out_reg.last_cell_out <= pass_reg[ST_OUT-1].last_cell;
            out_reg.momx_out      <= mom[0];
            out_reg.momy_out      <= mom[1];
            out_reg.momz_out      <= mom[2];
        end
    end

    assign m_data = out_reg;

`ifndef ASSERT_OFF
    a_stall_only_from_sink: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a full, stalled pipeline");

    a_denominator_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[ST_PREP] |-> (d8_reg >= 32'd65536))
        else $error("divisor below 1.0");

    a_remainder_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[ST_OUT-1] && !fin[0].ovf) |-> (fin[0].rem < {1'b0, div_d_reg[NDIV-1]}))
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire
